>>> src/clfq_pkg.sv
package clfq_pkg;

    localparam int CELL_COUNT_DEF   = 126;
    localparam int TEMP_COUNT_DEF   = 60;
    localparam int COUNT_WIDTH_DEF  = 8;

    localparam int PADDR_W = 5;

    localparam logic [1:0] KIND_VOLT = 2'd0;
    localparam logic [1:0] KIND_TEMP = 2'd1;
    localparam logic [1:0] KIND_CURR = 2'd2;

    typedef enum logic [2:0] {
        FAULT_OK         = 3'd0,
        FAULT_OVERVOLT   = 3'd1,
        FAULT_UNDERVOLT  = 3'd2,
        FAULT_OVERTEMP   = 3'd3,
        FAULT_UNDERTEMP  = 3'd4,
        FAULT_OVERCURR   = 3'd5,
        FAULT_UNDERCURR  = 3'd6,
        FAULT_SKIPPED    = 3'd7
    } t_fault;

    typedef enum logic [2:0] {
        REG_V_HI    = 3'd0,
        REG_V_LO    = 3'd1,
        REG_T_HI    = 3'd2,
        REG_T_LO    = 3'd3,
        REG_C_HI    = 3'd4,
        REG_C_LO    = 3'd5,
        REG_ALLOWED = 3'd6
    } t_reg_idx;

    localparam logic signed [15:0] V_HI_RST    = 16'sd4190;
    localparam logic signed [15:0] V_LO_RST    = 16'sd2810;
    localparam logic signed [15:0] T_HI_RST    = 16'sd600;
    localparam logic signed [15:0] T_LO_RST    = -16'sd200;
    localparam logic signed [15:0] C_HI_RST    = 16'sd1000;
    localparam logic signed [15:0] C_LO_RST    = -16'sd400;
    localparam logic [15:0]        ALLOWED_RST = 16'd3;

    typedef struct packed {
        logic signed [15:0] v_hi;
        logic signed [15:0] v_lo;
        logic signed [15:0] t_hi;
        logic signed [15:0] t_lo;
        logic signed [15:0] c_hi;
        logic signed [15:0] c_lo;
        logic [15:0]        allowed;
    } t_limits;

endpackage

>>> src/clfq_regs.sv
module clfq_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [clfq_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output clfq_pkg::t_limits             o_limits
);

    clfq_pkg::t_limits r_lim;
    logic              wr_en;
    logic [2:0]        reg_idx;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite;
    assign reg_idx  = paddr[4:2];
    assign o_limits = r_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim.v_hi    <= clfq_pkg::V_HI_RST;
            r_lim.v_lo    <= clfq_pkg::V_LO_RST;
            r_lim.t_hi    <= clfq_pkg::T_HI_RST;
            r_lim.t_lo    <= clfq_pkg::T_LO_RST;
            r_lim.c_hi    <= clfq_pkg::C_HI_RST;
            r_lim.c_lo    <= clfq_pkg::C_LO_RST;
            r_lim.allowed <= clfq_pkg::ALLOWED_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                clfq_pkg::REG_V_HI:    r_lim.v_hi    <= pwdata[15:0];
                clfq_pkg::REG_V_LO:    r_lim.v_lo    <= pwdata[15:0];
                clfq_pkg::REG_T_HI:    r_lim.t_hi    <= pwdata[15:0];
                clfq_pkg::REG_T_LO:    r_lim.t_lo    <= pwdata[15:0];
                clfq_pkg::REG_C_HI:    r_lim.c_hi    <= pwdata[15:0];
                clfq_pkg::REG_C_LO:    r_lim.c_lo    <= pwdata[15:0];
                clfq_pkg::REG_ALLOWED: r_lim.allowed <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            clfq_pkg::REG_V_HI:    prdata = {16'd0, r_lim.v_hi};
            clfq_pkg::REG_V_LO:    prdata = {16'd0, r_lim.v_lo};
            clfq_pkg::REG_T_HI:    prdata = {16'd0, r_lim.t_hi};
            clfq_pkg::REG_T_LO:    prdata = {16'd0, r_lim.t_lo};
            clfq_pkg::REG_C_HI:    prdata = {16'd0, r_lim.c_hi};
            clfq_pkg::REG_C_LO:    prdata = {16'd0, r_lim.c_lo};
            clfq_pkg::REG_ALLOWED: prdata = {16'd0, r_lim.allowed};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

>>> src/clfq_cnt_mem.sv
module clfq_cnt_mem #(
    parameter int DEPTH = 187,
    parameter int DW    = 16,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DW-1:0]    r_rd_data;
    logic             r_rd_valid;
    logic             r_fwd_hit;
    logic [DW-1:0]    r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // Entries never written read as zero; a write landing on the same edge as
    // the read is forwarded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
                r_fwd_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    assign o_rd_data = r_fwd_hit  ? r_fwd_data :
                       r_rd_valid ? r_rd_data  : '0;

endmodule

>>> src/consecutive_limit_fault_qualifier.sv
// Channel    Dir  Handshake              Content
// s_axis     in   tvalid/tready          tdata index+value, tuser kind, tlast end of scan
// m_axis     out  tvalid/tready          tdata fault code
// apb        in   psel/penable, pready   limit and tolerance registers
// One sample is taken every cycle unless the output stalls; fault codes are registered.
// The counter memory is read on the input transfer and written back from the update stage,
// with a forwarding register covering back-to-back samples of the same channel.
// Reset clears all counters at once through per-entry valid bits; no clearing pass.
// A stalled output holds one result in the output register and one in the update stage.
module consecutive_limit_fault_qualifier #(
    parameter int CELL_COUNT        = clfq_pkg::CELL_COUNT_DEF,
    parameter int TEMP_SENSOR_COUNT = clfq_pkg::TEMP_COUNT_DEF,
    parameter int COUNT_WIDTH       = clfq_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // channel_index[6:0], sample_value[22:7]
    input  logic [1:0]                    s_axis_tuser,  // channel_kind[1:0]
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // fault_code[2:0]
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [clfq_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int DEPTH = CELL_COUNT + TEMP_SENSOR_COUNT + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = COUNT_WIDTH;

    clfq_pkg::t_limits limits;

    logic [6:0]         in_idx;
    logic signed [15:0] in_value;
    logic [1:0]         in_kind;
    logic               in_accept;
    logic               in_ign;
    logic [AW-1:0]      rd_addr;

    logic               r_s1_valid;
    logic [1:0]         r_s1_kind;
    logic signed [15:0] r_s1_value;
    logic               r_s1_last;
    logic               r_s1_ign;
    logic [AW-1:0]      r_s1_addr;
    logic               r_scan_faulted;

    logic               s1_adv;
    logic [2*CW-1:0]    cnt_rd;
    logic [CW-1:0]      over_cnt;
    logic [CW-1:0]      under_cnt;
    logic [CW-1:0]      n_over;
    logic [CW-1:0]      n_under;
    logic signed [15:0] hi_lim;
    logic signed [15:0] lo_lim;
    logic               over_viol;
    logic               under_viol;
    clfq_pkg::t_fault   over_code;
    clfq_pkg::t_fault   under_code;
    clfq_pkg::t_fault   s1_code;
    logic               skip;
    logic               wr_en;

    logic               r_out_valid;
    clfq_pkg::t_fault   r_out_code;

    clfq_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_limits (limits)
    );

    assign in_idx   = s_axis_tdata[6:0];
    assign in_value = s_axis_tdata[22:7];
    assign in_kind  = s_axis_tuser;

    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_ign  = 1'b0;
        rd_addr = '0;
        case (in_kind)
            clfq_pkg::KIND_VOLT: begin
                in_ign  = ({1'b0, in_idx} >= 8'(CELL_COUNT));
                rd_addr = in_ign ? '0 : AW'(in_idx);
            end
            clfq_pkg::KIND_TEMP: begin
                in_ign  = ({1'b0, in_idx} >= 8'(TEMP_SENSOR_COUNT));
                rd_addr = in_ign ? '0 : AW'(CELL_COUNT) + AW'(in_idx);
            end
            clfq_pkg::KIND_CURR: begin
                rd_addr = AW'(CELL_COUNT + TEMP_SENSOR_COUNT);
            end
            default: begin
                in_ign = 1'b1;
            end
        endcase
    end

    clfq_cnt_mem #(
        .DEPTH (DEPTH),
        .DW    (2 * CW),
        .AW    (AW)
    ) u_cnt_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (cnt_rd),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data ({n_over, n_under})
    );

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_kind  <= in_kind;
            r_s1_value <= in_value;
            r_s1_last  <= s_axis_tlast;
            r_s1_ign   <= in_ign;
            r_s1_addr  <= rd_addr;
        end
    end

    assign over_cnt  = cnt_rd[2*CW-1:CW];
    assign under_cnt = cnt_rd[CW-1:0];

    always_comb begin
        case (r_s1_kind)
            clfq_pkg::KIND_VOLT: begin
                hi_lim     = limits.v_hi;
                lo_lim     = limits.v_lo;
                over_code  = clfq_pkg::FAULT_OVERVOLT;
                under_code = clfq_pkg::FAULT_UNDERVOLT;
            end
            clfq_pkg::KIND_TEMP: begin
                hi_lim     = limits.t_hi;
                lo_lim     = limits.t_lo;
                over_code  = clfq_pkg::FAULT_OVERTEMP;
                under_code = clfq_pkg::FAULT_UNDERTEMP;
            end
            default: begin
                hi_lim     = limits.c_hi;
                lo_lim     = limits.c_lo;
                over_code  = clfq_pkg::FAULT_OVERCURR;
                under_code = clfq_pkg::FAULT_UNDERCURR;
            end
        endcase
    end

    assign over_viol  = r_s1_value > hi_lim;
    assign under_viol = lo_lim > r_s1_value;

    always_comb begin
        if (!over_viol) begin
            n_over = '0;
        end else if (over_cnt != '1) begin
            n_over = over_cnt + 1'b1;
        end else begin
            n_over = over_cnt;
        end
        if (!under_viol) begin
            n_under = '0;
        end else if (under_cnt != '1) begin
            n_under = under_cnt + 1'b1;
        end else begin
            n_under = under_cnt;
        end
    end

    assign skip  = r_scan_faulted;
    assign wr_en = s1_adv && !skip && !r_s1_ign;

    always_comb begin
        if (skip) begin
            s1_code = clfq_pkg::FAULT_SKIPPED;
        end else if (r_s1_ign) begin
            s1_code = clfq_pkg::FAULT_OK;
        end else if (16'(n_over) > limits.allowed) begin
            s1_code = over_code;
        end else if (16'(n_under) > limits.allowed) begin
            s1_code = under_code;
        end else begin
            s1_code = clfq_pkg::FAULT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_scan_faulted <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                if (r_s1_last) begin
                    r_scan_faulted <= 1'b0;
                end else if (s1_code != clfq_pkg::FAULT_OK &&
                             s1_code != clfq_pkg::FAULT_SKIPPED) begin
                    r_scan_faulted <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_code <= s1_code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_code};

endmodule
